>>> design/pcps_pkg.sv
package pcps_pkg;

  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MOM_BITS   = 16;

  typedef enum logic [3:0] {
    MODE_TICK        = 4'd0,
    MODE_SAMPLE      = 4'd1,
    MODE_SET_PUB     = 4'd2,
    MODE_CONFIGURE   = 4'd3,
    MODE_ENABLE      = 4'd4,
    MODE_DISABLE     = 4'd5,
    MODE_TOGGLE      = 4'd6,
    MODE_PURGE       = 4'd7,
    MODE_PURGE_ALL   = 4'd8,
    MODE_DEFAULT     = 4'd9,
    MODE_DEFAULT_ALL = 4'd10
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_MOM_MASK    = 3'd1,
    REG_OFF_PERIOD  = 3'd2,
    REG_PRESS       = 3'd3,
    REG_RELEASE     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  flags;
    logic [31:0] current;
    logic [31:0] published;
    logic [31:0] last_time;
    logic        dirty;
  } entry_t;

  typedef struct packed {
    logic [15:0] off_period;
    logic [31:0] press_value;
    logic [31:0] release_value;
  } filt_cfg_t;

endpackage

>>> design/pcps_ram.sv
module pcps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/pcps_update.sv
module pcps_update (
  input  pcps_pkg::entry_t    entry_i,
  input  pcps_pkg::mode_e     mode_i,
  input  pcps_pkg::filt_cfg_t cfg_i,
  input  logic                momentary_i,
  input  logic [31:0]         data_i,
  input  logic [31:0]         time_i,
  input  logic [15:0]         period_i,
  input  logic [7:0]          flags_i,
  output pcps_pkg::entry_t    entry_o,
  output logic                due_o
);
  import pcps_pkg::*;

  logic [31:0] elapsed;
  logic        timing_ok;
  logic        filter_ok;
  logic        is_press;
  logic        is_release;
  logic        same_pub;

  assign elapsed    = time_i - entry_i.last_time;
  assign is_press   = (entry_i.current == cfg_i.press_value);
  assign is_release = (entry_i.current == cfg_i.release_value);
  assign same_pub   = (entry_i.current == entry_i.published);

  always_comb begin
    timing_ok = entry_i.flags[0] && (entry_i.period != cfg_i.off_period) &&
                (elapsed >= 32'(entry_i.period));
    // A momentary input only goes out on press or release, and a repeated
    // release is held back.
    if (momentary_i) begin
      filter_ok = (is_press || is_release) && !(is_release && same_pub);
    end else begin
      filter_ok = !(entry_i.flags[1] && same_pub);
    end
    due_o = timing_ok && filter_ok;
  end

  always_comb begin
    entry_o = entry_i;
    unique case (mode_i)
      MODE_TICK: begin
        entry_o.last_time = time_i;
        entry_o.published = entry_i.current;
      end
      MODE_SAMPLE:  entry_o.current = data_i;
      MODE_SET_PUB: entry_o.published = data_i;
      MODE_CONFIGURE: begin
        entry_o.period = period_i;
        entry_o.flags  = flags_i;
        entry_o.dirty  = 1'b1;
      end
      MODE_ENABLE: begin
        entry_o.flags[0] = 1'b1;
        entry_o.dirty    = 1'b1;
      end
      MODE_DISABLE: begin
        entry_o.flags[0] = 1'b0;
        entry_o.dirty    = 1'b1;
      end
      MODE_TOGGLE: begin
        entry_o.flags[0] = ~entry_i.flags[0];
        entry_o.dirty    = 1'b1;
      end
      MODE_PURGE, MODE_PURGE_ALL: begin
        entry_o.period    = '0;
        entry_o.current   = '0;
        entry_o.published = '0;
        entry_o.dirty     = 1'b1;
      end
      MODE_DEFAULT, MODE_DEFAULT_ALL: begin
        entry_o.period    = cfg_i.off_period;
        entry_o.flags     = '0;
        entry_o.current   = '0;
        entry_o.published = '0;
        entry_o.dirty     = 1'b1;
      end
      default: entry_o = entry_i;
    endcase
  end

endmodule

>>> design/periodic_change_publish_scheduler.sv
// Channel   | Direction | Transfer condition
// ----------+-----------+------------------------------------------------
// command   | in        | start_i high while busy_o low
// result    | out       | done_o high for one cycle, always taken
// config    | in        | cfg_valid_i and cfg_ready_o both high
//
// All entry state sits in one synchronous RAM with one read and one write port.
// A single-entry op reads, updates and writes back its entry; a tick or bulk op
// visits one entry per cycle, set by the single RAM read port, and a tick stops
// at the first entry that is due to publish.
// Reset clears the entry valid bits at once, so no clearing pass is needed.
// The result receiver cannot stall; a new command may start in the cycle of
// the result strobe.
module periodic_change_publish_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [3:0]                     mode_i,
  input  logic [5:0]                     entry_index_i,
  input  logic [31:0]                    data_value_i,
  input  logic [31:0]                    time_ms_i,
  input  logic [15:0]                    new_period_i,
  input  logic [7:0]                     new_flags_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           done_o,
  output logic                           accepted_o,
  output logic                           publish_ready_o,
  output logic [5:0]                     publish_index_o,
  output logic [31:0]                    publish_value_o,
  output logic                           entry_dirty_o
);
  import pcps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_SCAN,
    S_BULK
  } state_e;

  state_e            state_q;
  mode_e             mode_q;
  mode_e             mode_in;
  logic [31:0]       data_q;
  logic [31:0]       time_q;
  logic [15:0]       nper_q;
  logic [7:0]        nflags_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  n_cur;
  logic [CNT_W-1:0]  rd_ptr_q;
  logic [IDX_W-1:0]  ent_ptr_q;

  logic [4:0]        entry_count_q;
  logic [15:0]       mom_mask_q;
  filt_cfg_t         cfg_q;

  logic [TABLE_SIZE-1:0] valid_q;
  logic                  vld_rd_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  entry_t            rd_entry;
  entry_t            new_entry;
  logic              due;
  logic              momentary;
  logic              idx_ok;
  logic              cfg_idx_ok;
  logic              single_ok;
  logic              last_entry;

  logic              done_q;
  logic              acc_q;
  logic              pub_rdy_q;
  logic [5:0]        pub_idx_q;
  logic [31:0]       pub_val_q;
  logic              dirty_q;

  assign cfg_ready_o     = 1'b1;
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign accepted_o      = acc_q;
  assign publish_ready_o = pub_rdy_q;
  assign publish_index_o = pub_idx_q;
  assign publish_value_o = pub_val_q;
  assign entry_dirty_o   = dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q       <= 5'd16;
      mom_mask_q          <= '0;
      cfg_q.off_period    <= '0;
      cfg_q.press_value   <= 32'd1;
      cfg_q.release_value <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENTRY_COUNT: entry_count_q       <= cfg_data_i[4:0];
        REG_MOM_MASK:    mom_mask_q          <= cfg_data_i[15:0];
        REG_OFF_PERIOD:  cfg_q.off_period    <= cfg_data_i[15:0];
        REG_PRESS:       cfg_q.press_value   <= cfg_data_i;
        REG_RELEASE:     cfg_q.release_value <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_in = mode_e'(mode_i);
    if (32'(entry_count_q) > 32'(TABLE_SIZE)) begin
      n_cur = CNT_W'(TABLE_SIZE);
    end else begin
      n_cur = CNT_W'(entry_count_q);
    end
    idx_ok     = (32'(entry_index_i) < 32'(TABLE_SIZE));
    cfg_idx_ok = idx_ok && (32'(entry_index_i) < 32'(n_cur));
    unique case (mode_in)
      MODE_SAMPLE, MODE_SET_PUB, MODE_ENABLE, MODE_DISABLE,
      MODE_TOGGLE, MODE_PURGE, MODE_DEFAULT: single_ok = idx_ok;
      MODE_CONFIGURE:                        single_ok = cfg_idx_ok;
      default:                               single_ok = 1'b0;
    endcase
  end

  // Entries never written since reset read as zero.
  assign rd_entry   = vld_rd_q ? ram_rdata : '0;
  assign momentary  = (32'(ent_ptr_q) < 32'(MOM_BITS)) && mom_mask_q[4'(ent_ptr_q)];
  assign last_entry = (rd_ptr_q == n_q);

  always_comb begin
    if (state_q == S_IDLE) begin
      ram_raddr = single_ok ? entry_index_i[IDX_W-1:0] : '0;
    end else begin
      ram_raddr = rd_ptr_q[IDX_W-1:0];
    end
    ram_we = (state_q == S_SINGLE) || (state_q == S_BULK) ||
             ((state_q == S_SCAN) && due);
  end

  pcps_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ent_ptr_q),
    .wdata_i(new_entry),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pcps_update u_update (
    .entry_i    (rd_entry),
    .mode_i     (mode_q),
    .cfg_i      (cfg_q),
    .momentary_i(momentary),
    .data_i     (data_q),
    .time_i     (time_q),
    .period_i   (nper_q),
    .flags_i    (nflags_q),
    .entry_o    (new_entry),
    .due_o      (due)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ent_ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_TICK;
      data_q    <= '0;
      time_q    <= '0;
      nper_q    <= '0;
      nflags_q  <= '0;
      n_q       <= '0;
      rd_ptr_q  <= '0;
      ent_ptr_q <= '0;
      done_q    <= 1'b0;
      acc_q     <= 1'b0;
      pub_rdy_q <= 1'b0;
      pub_idx_q <= '0;
      pub_val_q <= '0;
      dirty_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            mode_q    <= mode_in;
            data_q    <= data_value_i;
            time_q    <= time_ms_i;
            nper_q    <= new_period_i;
            nflags_q  <= new_flags_i;
            n_q       <= n_cur;
            rd_ptr_q  <= CNT_W'(1);
            ent_ptr_q <= single_ok ? entry_index_i[IDX_W-1:0] : '0;
            acc_q     <= 1'b0;
            pub_rdy_q <= 1'b0;
            pub_idx_q <= '0;
            pub_val_q <= '0;
            dirty_q   <= 1'b0;
            unique case (mode_in)
              MODE_TICK, MODE_PURGE_ALL, MODE_DEFAULT_ALL: begin
                if (n_cur == '0) begin
                  done_q <= 1'b1;
                  acc_q  <= 1'b1;
                end else if (mode_in == MODE_TICK) begin
                  state_q <= S_SCAN;
                end else begin
                  state_q <= S_BULK;
                end
              end
              default: begin
                if (single_ok) begin
                  state_q <= S_SINGLE;
                end else begin
                  done_q <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SINGLE: begin
          done_q  <= 1'b1;
          acc_q   <= 1'b1;
          dirty_q <= new_entry.dirty;
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (due) begin
            done_q    <= 1'b1;
            acc_q     <= 1'b1;
            pub_rdy_q <= 1'b1;
            pub_idx_q <= 6'(ent_ptr_q);
            pub_val_q <= rd_entry.current;
            dirty_q   <= rd_entry.dirty;
            state_q   <= S_IDLE;
          end else if (last_entry) begin
            done_q  <= 1'b1;
            acc_q   <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            ent_ptr_q <= rd_ptr_q[IDX_W-1:0];
            rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
          end
        end
        S_BULK: begin
          if (last_entry) begin
            done_q  <= 1'b1;
            acc_q   <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            ent_ptr_q <= rd_ptr_q[IDX_W-1:0];
            rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/periodic_change_publish_scheduler_tb.sv
module periodic_change_publish_scheduler_tb;
  import pcps_pkg::*;

  localparam logic [3:0] SPARE_MODE_LO = 4'd11;
  localparam logic [3:0] SPARE_MODE_HI = 4'd15;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 150;

  typedef struct packed {
    logic [3:0]  mode;
    logic [5:0]  index;
    logic [31:0] data;
    logic [31:0] stamp;
    logic [15:0] period;
    logic [7:0]  flags;
  } command_t;

  typedef struct packed {
    logic        accepted;
    logic        ready;
    logic [5:0]  index;
    logic [31:0] value;
    logic        dirty;
  } reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [3:0]           mode_i = '0;
  logic [5:0]           entry_index_i = '0;
  logic [31:0]          data_value_i = '0;
  logic [31:0]          time_ms_i = '0;
  logic [15:0]          new_period_i = '0;
  logic [7:0]           new_flags_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 done_o;
  logic                 accepted_o;
  logic                 publish_ready_o;
  logic [5:0]           publish_index_o;
  logic [31:0]          publish_value_o;
  logic                 entry_dirty_o;

  // Shadow copy of the publisher table and its settings.
  logic [15:0] period_q [TABLE_SIZE];
  logic [7:0]  flags_q [TABLE_SIZE];
  logic [31:0] current_q [TABLE_SIZE];
  logic [31:0] published_q [TABLE_SIZE];
  logic [31:0] last_time_q [TABLE_SIZE];
  logic        dirty_q [TABLE_SIZE];
  logic [4:0]  count_q;
  logic [15:0] momentary_q;
  logic [15:0] off_period_q;
  logic [31:0] press_q;
  logic [31:0] release_q;

  reply_t      replies_due[$];
  int unsigned failures = 0;
  int unsigned commands_sent = 0;
  int unsigned replies_seen = 0;
  int unsigned publishes_due = 0;
  int unsigned refusals_due = 0;
  int unsigned config_writes = 0;

  periodic_change_publish_scheduler dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic reply_t apply_to_table(input command_t c);
    reply_t      r;
    int unsigned used;
    logic [3:0]  e;
    logic [31:0] val;
    logic [31:0] elapsed;
    logic        ok;
    logic        single;
    r = '0;
    used = (count_q > TABLE_SIZE) ? TABLE_SIZE : count_q;
    e = c.index[3:0];
    if (c.mode == MODE_TICK) begin
      r.accepted = 1'b1;
      for (int i = 0; i < used; i++) begin
        val = current_q[i];
        elapsed = c.stamp - last_time_q[i];
        if (!flags_q[i][0] || period_q[i] == off_period_q || elapsed < 32'(period_q[i]))
          continue;
        if (momentary_q[i]) begin
          if (val != press_q && val != release_q) continue;
          if (val == release_q && val == published_q[i]) continue;
        end else if (flags_q[i][1] && val == published_q[i]) begin
          continue;
        end
        last_time_q[i] = c.stamp;
        published_q[i] = val;
        r.ready = 1'b1;
        r.index = 6'(i);
        r.value = val;
        r.dirty = dirty_q[i];
        break;
      end
      if (r.ready) publishes_due++;
      return r;
    end
    single = 1'b0;
    case (c.mode)
      MODE_SAMPLE, MODE_SET_PUB, MODE_ENABLE, MODE_DISABLE, MODE_TOGGLE, MODE_PURGE,
      MODE_DEFAULT: begin
        ok = c.index < TABLE_SIZE;
        single = 1'b1;
      end
      MODE_CONFIGURE: begin
        ok = c.index < TABLE_SIZE && c.index < used;
        single = 1'b1;
      end
      MODE_PURGE_ALL, MODE_DEFAULT_ALL: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      refusals_due++;
      return r;
    end
    case (c.mode)
      MODE_SAMPLE:  current_q[e] = c.data;
      MODE_SET_PUB: published_q[e] = c.data;
      MODE_CONFIGURE: begin
        period_q[e] = c.period;
        flags_q[e] = c.flags;
        dirty_q[e] = 1'b1;
      end
      MODE_ENABLE: begin
        flags_q[e][0] = 1'b1;
        dirty_q[e] = 1'b1;
      end
      MODE_DISABLE: begin
        flags_q[e][0] = 1'b0;
        dirty_q[e] = 1'b1;
      end
      MODE_TOGGLE: begin
        flags_q[e][0] = ~flags_q[e][0];
        dirty_q[e] = 1'b1;
      end
      default: begin
        // Purge and default, single or bulk; flags and publish time survive a purge.
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if ((single && i == e) || (!single && i < used)) begin
            period_q[i] = '0;
            current_q[i] = '0;
            published_q[i] = '0;
            dirty_q[i] = 1'b1;
            if (c.mode == MODE_DEFAULT || c.mode == MODE_DEFAULT_ALL) begin
              period_q[i] = off_period_q;
              flags_q[i] = '0;
            end
          end
        end
      end
    endcase
    r.accepted = 1'b1;
    if (single) r.dirty = dirty_q[e];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return press_q;
      1: return release_q;
      2: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // The command stays on the inputs until the transfer; start is only lowered by a
  // hold-off, a configuration write or the end of the run, so back-to-back items keep it high.
  task automatic send_cmd(logic [3:0] mode, logic [5:0] index, logic [31:0] data,
                          logic [31:0] stamp, logic [15:0] period, logic [7:0] flags);
    command_t c;
    c = '{mode, index, data, stamp, period, flags};
    @(negedge clk_i);
    start_i <= 1'b1;
    mode_i <= mode;
    entry_index_i <= index;
    data_value_i <= data;
    time_ms_i <= stamp;
    new_period_i <= period;
    new_flags_i <= flags;
    do @(posedge clk_i); while (busy_o);
    replies_due.push_back(apply_to_table(c));
    commands_sent++;
  endtask

  task automatic hold_off(int unsigned cycles);
    repeat (cycles) @(negedge clk_i) start_i <= 1'b0;
  endtask

  task automatic write_reg(cfg_reg_e which, logic [31:0] value);
    @(negedge clk_i) start_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (which)
      REG_ENTRY_COUNT: count_q = value[4:0];
      REG_MOM_MASK:    momentary_q = value[15:0];
      REG_OFF_PERIOD:  off_period_q = value[15:0];
      REG_PRESS:       press_q = value;
      REG_RELEASE:     release_q = value;
      default: ;
    endcase
    config_writes++;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && done_o) begin
      if (replies_due.size() == 0) begin
        $error("result strobe with no command outstanding");
        failures++;
      end else begin
        want = replies_due.pop_front();
        replies_seen++;
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted_o);
          failures++;
        end
        if (publish_ready_o !== want.ready) begin
          $error("publish_ready: expected %0d, got %0d", want.ready, publish_ready_o);
          failures++;
        end
        if (publish_index_o !== want.index) begin
          $error("publish_index: expected %0d, got %0d", want.index, publish_index_o);
          failures++;
        end
        if (publish_value_o !== want.value) begin
          $error("publish_value: expected %h, got %h", want.value, publish_value_o);
          failures++;
        end
        if (entry_dirty_o !== want.dirty) begin
          $error("entry_dirty: expected %0d, got %0d", want.dirty, entry_dirty_o);
          failures++;
        end
      end
    end
  end

  task automatic test_single_entry_ops();
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_CONFIGURE, 6'd0, 32'd0, 32'd0, 16'd10, 8'h01);
    send_cmd(MODE_SAMPLE, 6'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd9, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd10, 16'd0, 8'h00);
    // Period equal to the off value never publishes.
    send_cmd(MODE_CONFIGURE, 6'd1, 32'd0, 32'd0, 16'd0, 8'h03);
    send_cmd(MODE_CONFIGURE, 6'd2, 32'd0, 32'd0, 16'd5, 8'h03);
    send_cmd(MODE_SAMPLE, 6'd2, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd20, 16'd0, 8'h00);
    send_cmd(MODE_SET_PUB, 6'd2, 32'h1234, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd21, 16'd0, 8'h00);
    send_cmd(MODE_DISABLE, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TOGGLE, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_ENABLE, 6'd3, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TOGGLE, 6'd3, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_PURGE, 6'd2, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_CONFIGURE, 6'd15, 32'd0, 32'd0, 16'hFFFF, 8'hFF);
    // A wrapped millisecond count still has to clear the full period.
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 8'h00);
    send_cmd(MODE_DEFAULT, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_SAMPLE, 6'd63, 32'hFFFF_FFFF, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_CONFIGURE, 6'd16, 32'd0, 32'd0, 16'd1, 8'h01);
    send_cmd(SPARE_MODE_HI, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(SPARE_MODE_LO, 6'd1, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_PURGE_ALL, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_DEFAULT_ALL, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
  endtask

  task automatic test_momentary_inputs();
    write_reg(REG_MOM_MASK, 32'h0000_8005);
    write_reg(REG_OFF_PERIOD, 32'h0000_FFFF);
    write_reg(REG_PRESS, 32'hAAAA_5555);
    write_reg(REG_RELEASE, 32'h5555_AAAA);
    send_cmd(MODE_CONFIGURE, 6'd0, 32'd0, 32'd0, 16'd2, 8'h01);
    send_cmd(MODE_SAMPLE, 6'd0, 32'd7, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd100, 16'd0, 8'h00);
    send_cmd(MODE_SAMPLE, 6'd0, 32'hAAAA_5555, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd101, 16'd0, 8'h00);
    send_cmd(MODE_SAMPLE, 6'd0, 32'h5555_AAAA, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd103, 16'd0, 8'h00);
    // Release already published: stays quiet.
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd110, 16'd0, 8'h00);
    send_cmd(MODE_CONFIGURE, 6'd15, 32'd0, 32'd0, 16'd0, 8'h03);
    send_cmd(MODE_SAMPLE, 6'd15, 32'hAAAA_5555, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd111, 16'd0, 8'h00);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd112, 16'd0, 8'h00);
  endtask

  task automatic test_entry_count();
    write_reg(REG_ENTRY_COUNT, 32'd0);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd200, 16'd0, 8'h00);
    send_cmd(MODE_CONFIGURE, 6'd0, 32'd0, 32'd0, 16'd1, 8'h01);
    send_cmd(MODE_PURGE_ALL, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
    send_cmd(MODE_SAMPLE, 6'd3, 32'd5, 32'd0, 16'd0, 8'h00);
    write_reg(REG_ENTRY_COUNT, 32'd1);
    send_cmd(MODE_CONFIGURE, 6'd0, 32'd0, 32'd0, 16'd0, 8'h01);
    send_cmd(MODE_CONFIGURE, 6'd1, 32'd0, 32'd0, 16'd0, 8'h01);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd201, 16'd0, 8'h00);
    // Counts above the table size saturate, whatever the upper data bits hold.
    write_reg(REG_ENTRY_COUNT, 32'hA5A5_A5BF);
    send_cmd(MODE_CONFIGURE, 6'd15, 32'd0, 32'd0, 16'd1, 8'h01);
    send_cmd(MODE_TICK, 6'd0, 32'd0, 32'd300, 16'd0, 8'h00);
    write_reg(REG_ENTRY_COUNT, 32'd17);
    send_cmd(MODE_CONFIGURE, 6'd16, 32'd0, 32'd0, 16'd1, 8'h01);
    send_cmd(MODE_DEFAULT_ALL, 6'd0, 32'd0, 32'd0, 16'd0, 8'h00);
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    int unsigned used;
    int unsigned burst;
    logic        gaps_on;
    logic [31:0] clock_ms;
    logic [31:0] data;
    logic [3:0]  mode;
    logic [5:0]  index;
    logic [15:0] period;
    logic [7:0]  flags;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: write_reg(REG_ENTRY_COUNT, 32'd16);
        1: write_reg(REG_ENTRY_COUNT, $urandom_range(1, 4));
        2: write_reg(REG_ENTRY_COUNT, $urandom() | 32'd16);
        default: write_reg(REG_ENTRY_COUNT, $urandom_range(5, 16));
      endcase
      case (phase % 4)
        0: write_reg(REG_MOM_MASK, 32'd0);
        1: write_reg(REG_MOM_MASK, 32'hFFFF_FFFF);
        default: write_reg(REG_MOM_MASK, $urandom());
      endcase
      case (phase % 3)
        0: write_reg(REG_OFF_PERIOD, 32'd0);
        1: write_reg(REG_OFF_PERIOD, 32'h0000_FFFF);
        default: write_reg(REG_OFF_PERIOD, $urandom_range(0, 8));
      endcase
      case (phase % 3)
        0: begin
          write_reg(REG_PRESS, 32'd1);
          write_reg(REG_RELEASE, 32'd0);
        end
        1: begin
          write_reg(REG_PRESS, $urandom());
          write_reg(REG_RELEASE, $urandom());
        end
        default: begin
          // Press and release may coincide.
          data = $urandom_range(0, 3);
          write_reg(REG_PRESS, data);
          write_reg(REG_RELEASE, (phase == 2) ? data : 32'hFFFF_FFFF);
        end
      endcase
      used = (count_q > TABLE_SIZE) ? TABLE_SIZE : count_q;
      clock_ms = (phase == 5) ? 32'hFFFF_FF00 : $urandom();
      gaps_on = (phase % 3 != 0);
      burst = $urandom_range(1, 24);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        data = $urandom();
        period = 16'($urandom());
        flags = 8'($urandom());
        r = $urandom_range(0, 99);
        if (r < 70) index = 6'($urandom_range(0, TABLE_SIZE - 1));
        else if (r < 85) index = 6'($urandom_range(0, used - 1));
        else index = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 35) begin
          mode = MODE_TICK;
          case ($urandom_range(0, 9))
            0: clock_ms += $urandom();
            1, 2: clock_ms += $urandom_range(5, 40);
            default: clock_ms += $urandom_range(0, 4);
          endcase
        end else if (r < 55) begin
          mode = MODE_SAMPLE;
          data = pick_value();
        end else if (r < 60) begin
          mode = MODE_SET_PUB;
          data = pick_value();
        end else if (r < 72) begin
          mode = MODE_CONFIGURE;
          case ($urandom_range(0, 9))
            0, 1: period = off_period_q;
            2: period = '0;
            3: period = 16'hFFFF;
            4: ;
            default: period = 16'($urandom_range(1, 8));
          endcase
          if ($urandom_range(0, 9) < 7) flags[0] = 1'b1;
        end else if (r < 76) mode = MODE_ENABLE;
        else if (r < 80) mode = MODE_DISABLE;
        else if (r < 84) mode = MODE_TOGGLE;
        else if (r < 88) mode = MODE_PURGE;
        else if (r < 91) mode = MODE_DEFAULT;
        else if (r < 93) mode = MODE_PURGE_ALL;
        else if (r < 95) mode = MODE_DEFAULT_ALL;
        else mode = 4'($urandom_range(SPARE_MODE_LO, SPARE_MODE_HI));
        send_cmd(mode, index, data, (mode == MODE_TICK) ? clock_ms : $urandom(), period, flags);
        if (gaps_on) begin
          burst--;
          if (burst == 0) begin
            hold_off($urandom_range(1, 8));
            burst = $urandom_range(1, 24);
          end
        end
      end
    end
  endtask

  initial begin
    count_q = 5'd16;
    momentary_q = '0;
    off_period_q = '0;
    press_q = 32'd1;
    release_q = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      period_q[i] = '0;
      flags_q[i] = '0;
      current_q[i] = '0;
      published_q[i] = '0;
      last_time_q[i] = '0;
      dirty_q[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_single_entry_ops();
    test_momentary_inputs();
    test_entry_count();
    test_random_traffic();

    @(negedge clk_i) start_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (TABLE_SIZE + 4) @(posedge clk_i);
    $display("Ran %0d commands over %0d register writes; %0d results checked.",
             commands_sent, config_writes, replies_seen);
    $display("Of those, %0d publishes and %0d refused or unknown operations.",
             publishes_due, refusals_due);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
